// ----- rtl/saa_pkg.sv -----
// ----------------------------------------------------------------------------
// saa_pkg
// shared constants and types of the scoped arena allocator
// ----------------------------------------------------------------------------
package saa_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int CNT_W       = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int DEPTH_OUT_W = 8;

    localparam logic [CNT_W-1:0]  CNT_MAX      = CNT_W'(STACK_DEPTH - 1);
    localparam logic [DATA_W-1:0] CAPACITY_RST = 32'd67108864;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_ENTER = 2'd1,
        FUNC_EXIT  = 2'd2,
        FUNC_RESET = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_ZERO_SIZE    = 3'd1,
        STATUS_OUT_OF_SPACE = 3'd2,
        STATUS_STACK_FULL   = 3'd3,
        STATUS_STACK_EMPTY  = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

endpackage

// ----- rtl/saa_mark_ram.sv -----
// ----------------------------------------------------------------------------
// saa_mark_ram
// simple dual-port ram for saved marks, one write and one registered read
// ----------------------------------------------------------------------------
module saa_mark_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ----- rtl/scoped_arena_allocator.sv -----
// ----------------------------------------------------------------------------
// scoped_arena_allocator
// bump allocator with a stack of saved cursor marks
// ----------------------------------------------------------------------------
// requests arrive on the input channel (i_in_valid / o_in_ready) carrying
// i_func and i_alloc_size; one result per request leaves on the output
// channel (o_out_valid / i_out_ready) from an output register.
// allocate, enter scope, reset and every refused request: the result is
// valid the cycle after the transfer and the next request can be taken
// that same cycle, so one request per cycle while the receiver keeps up.
// a successful exit scope reads the mark ram, whose read data is
// registered, so it goes through the pop state, which holds off the input.
// the user writes the capacity register via i_cfg_wr_en / i_cfg_wr_data only
// while the block is idle (not enforced); it affects only later allocations.
// reset (i_rst_n low, synchronous) clears the cursor, the mark count and
// the capacity to 64 MiB; the mark ram keeps its contents, since only
// entries pushed after reset are ever read back.
// when the receiver stalls the result holds and no new request is taken
// until the output register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
module scoped_arena_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [saa_pkg::DATA_W-1:0]      i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_func,
    input  logic [saa_pkg::DATA_W-1:0]      i_alloc_size,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [saa_pkg::DATA_W-1:0]      o_offset,
    output logic [2:0]                      o_status,
    output logic [saa_pkg::DATA_W-1:0]      o_used_bytes,
    output logic [saa_pkg::DEPTH_OUT_W-1:0] o_mark_depth
);

    saa_pkg::t_state                    r_state, n_state;
    logic [saa_pkg::DATA_W-1:0]         r_capacity;
    logic [saa_pkg::DATA_W-1:0]         r_cursor, n_cursor;
    logic [saa_pkg::CNT_W-1:0]          r_count, n_count;
    logic                               r_out_valid, n_out_valid;
    logic [saa_pkg::DATA_W-1:0]         r_offset, n_offset;
    saa_pkg::t_status                   r_status, n_status;
    logic [saa_pkg::DATA_W-1:0]         r_used, n_used;
    logic [saa_pkg::DEPTH_OUT_W-1:0]    r_depth, n_depth;

    logic                               w_in_fire;
    logic                               w_out_free;
    logic [saa_pkg::DATA_W:0]           w_sum;
    logic [saa_pkg::CNT_W-1:0]          w_count_inc;
    logic [saa_pkg::CNT_W-1:0]          w_count_dec;
    logic                               w_ram_we;
    logic                               w_ram_re;
    logic [saa_pkg::DATA_W-1:0]         w_ram_rdata;
    saa_pkg::t_func                     w_func;

    assign w_func      = saa_pkg::t_func'(i_func);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == saa_pkg::ST_IDLE) && w_out_free;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_sum       = {1'b0, r_cursor} + {1'b0, i_alloc_size};
    assign w_count_inc = r_count + 1'b1;
    assign w_count_dec = r_count - 1'b1;

    assign w_ram_we = w_in_fire && (w_func == saa_pkg::FUNC_ENTER) &&
                      (r_count != saa_pkg::CNT_MAX);
    assign w_ram_re = w_in_fire && (w_func == saa_pkg::FUNC_EXIT) &&
                      (r_count != '0);

    saa_mark_ram #(
        .DEPTH (saa_pkg::STACK_DEPTH),
        .WIDTH (saa_pkg::DATA_W)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count),
        .i_wdata (r_cursor),
        .i_re    (w_ram_re),
        .i_raddr (w_count_dec),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= saa_pkg::ST_IDLE;
            r_capacity  <= saa_pkg::CAPACITY_RST;
            r_cursor    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset <= n_offset;
        r_status <= n_status;
        r_used   <= n_used;
        r_depth  <= n_depth;
    end

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_offset    = r_offset;
        n_status    = r_status;
        n_used      = r_used;
        n_depth     = r_depth;
        unique case (r_state)
            saa_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    n_out_valid = 1'b1;
                    n_offset    = r_cursor;
                    n_status    = saa_pkg::STATUS_OK;
                    unique case (w_func)
                        saa_pkg::FUNC_ALLOC: begin
                            if (i_alloc_size == '0) begin
                                n_status = saa_pkg::STATUS_ZERO_SIZE;
                            end else if (w_sum >= {1'b0, r_capacity}) begin
                                n_status = saa_pkg::STATUS_OUT_OF_SPACE;
                            end else begin
                                n_cursor = w_sum[saa_pkg::DATA_W-1:0];
                            end
                        end
                        saa_pkg::FUNC_ENTER: begin
                            if (r_count == saa_pkg::CNT_MAX) begin
                                n_status = saa_pkg::STATUS_STACK_FULL;
                            end else begin
                                n_count = w_count_inc;
                            end
                        end
                        saa_pkg::FUNC_EXIT: begin
                            if (r_count == '0) begin
                                n_status = saa_pkg::STATUS_STACK_EMPTY;
                            end else begin
                                // mark arrives from the ram next cycle
                                n_out_valid = 1'b0;
                                n_state     = saa_pkg::ST_POP;
                            end
                        end
                        saa_pkg::FUNC_RESET: begin
                            n_cursor = '0;
                            n_count  = '0;
                        end
                        default: begin
                            n_status = saa_pkg::STATUS_OK;
                        end
                    endcase
                    n_used  = n_cursor;
                    n_depth = saa_pkg::DEPTH_OUT_W'(n_count);
                end
            end
            saa_pkg::ST_POP: begin
                n_cursor    = w_ram_rdata;
                n_count     = w_count_dec;
                n_out_valid = 1'b1;
                n_offset    = r_cursor;
                n_status    = saa_pkg::STATUS_OK;
                n_used      = w_ram_rdata;
                n_depth     = saa_pkg::DEPTH_OUT_W'(w_count_dec);
                n_state     = saa_pkg::ST_IDLE;
            end
            default: begin
                n_state = saa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_offset     = r_offset;
    assign o_status     = r_status;
    assign o_used_bytes = r_used;
    assign o_mark_depth = r_depth;

`ifndef NO_ASSERTIONS
    // a pop always goes through the ram wait state
    a_pop_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_re |=> (r_state == saa_pkg::ST_POP) && !r_out_valid)
        else $error("exit scope did not wait for mark read");

    // every other transfer yields a result in the next cycle
    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !w_ram_re) |=> r_out_valid)
        else $error("result missing after transfer");

    // the mark count never passes the stack limit
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= saa_pkg::CNT_MAX)
        else $error("mark count beyond stack limit");

    // a push and a pop never hit the ram in the same cycle
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("mark ram read and write together");

    // a granted push advances the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |=> (r_count == $past(w_count_inc)))
        else $error("push did not advance mark count");
`endif

endmodule
